// ===== sv/multiwidth_integer_alu_macros.svh =====
// Assertion macros for the multi-width integer ALU, used by the queue module.
`ifndef MULTIWIDTH_INTEGER_ALU_MACROS_SVH
`define MULTIWIDTH_INTEGER_ALU_MACROS_SVH
`ifndef SYNTH
`define MIA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MIA_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MIA_ASSERT(lbl, clk, rstn, prop, msg)
`define MIA_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== sv/mia_pkg.sv =====
// Types and codes shared by the multi-width integer ALU.
`timescale 1ns / 1ps
package mia_pkg;

    localparam logic [1:0] ACT_UNARY   = 2'd0;
    localparam logic [1:0] ACT_BINARY  = 2'd1;
    localparam logic [1:0] ACT_COMPARE = 2'd2;
    localparam logic [1:0] ACT_CAST    = 2'd3;

    localparam logic [3:0] UN_NEG = 4'd0;
    localparam logic [3:0] UN_NOT = 4'd1;

    localparam logic [3:0] BIN_ADD  = 4'd0;
    localparam logic [3:0] BIN_SUB  = 4'd1;
    localparam logic [3:0] BIN_MUL  = 4'd2;
    localparam logic [3:0] BIN_MODU = 4'd3;
    localparam logic [3:0] BIN_DIVU = 4'd4;
    localparam logic [3:0] BIN_MODS = 4'd5;
    localparam logic [3:0] BIN_DIVS = 4'd6;
    localparam logic [3:0] BIN_SHR  = 4'd7;
    localparam logic [3:0] BIN_SHL  = 4'd8;
    localparam logic [3:0] BIN_SAR  = 4'd9;
    localparam logic [3:0] BIN_AND  = 4'd10;
    localparam logic [3:0] BIN_OR   = 4'd11;
    localparam logic [3:0] BIN_XOR  = 4'd12;

    localparam logic [3:0] CMP_EQ  = 4'd0;
    localparam logic [3:0] CMP_NE  = 4'd1;
    localparam logic [3:0] CMP_GTU = 4'd2;
    localparam logic [3:0] CMP_GEU = 4'd3;
    localparam logic [3:0] CMP_GTS = 4'd4;
    localparam logic [3:0] CMP_GES = 4'd5;
    localparam logic [3:0] CMP_LTU = 4'd6;
    localparam logic [3:0] CMP_LEU = 4'd7;
    localparam logic [3:0] CMP_LTS = 4'd8;
    localparam logic [3:0] CMP_LES = 4'd9;

    localparam logic [3:0] CAST_SEXT = 4'd3;

    localparam logic [2:0] WC_8  = 3'd0;
    localparam logic [2:0] WC_16 = 3'd1;
    localparam logic [2:0] WC_32 = 3'd2;
    localparam logic [2:0] WC_64 = 3'd3;
    localparam logic [2:0] WC_1  = 3'd4;

    localparam logic [1:0] CLS_SIMPLE = 2'd0;
    localparam logic [1:0] CLS_MUL    = 2'd1;
    localparam logic [1:0] CLS_QUOT   = 2'd2;
    localparam logic [1:0] CLS_REM    = 2'd3;

    localparam int DATA_W      = 64;
    localparam int DIV_STAGES  = DATA_W;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]        action;
        logic [3:0]        opcode;
        logic [2:0]        width_code;
        logic [2:0]        target_width_code;
        logic [DATA_W-1:0] left_operand;
        logic [DATA_W-1:0] right_operand;
    } in_t;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              error_flag;
    } out_t;

    typedef struct packed {
        logic [1:0]        cls;
        logic              err;
        logic              neg;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] mask;
    } work_t;

endpackage

// ===== sv/multiwidth_integer_alu.sv =====
// Top level of the multi-width integer ALU: front end, queue and back end.
//
//  channel | direction | handshake          | beat
//  in      | input     | in_valid/in_ready  | in_data (action, opcode, widths, operands)
//  out     | output    | out_valid/out_ready| out_data (result_value, error_flag)
//
// One beat is accepted per cycle while the queue has room; results leave one per cycle
// while out_ready is high. A beat passes through the queue entry, the entry stage,
// the 64-stage divider pipeline and the output register.
// Reset clears the queue, the pipeline valid bits and the output valid.
// A stalled output freezes the back end; the queue of four then fills before in_ready drops.
`timescale 1ns / 1ps
module multiwidth_integer_alu (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mia_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output mia_pkg::out_t out_data
);

    mia_pkg::work_t work, q_data;
    logic           full, empty, q_pop;

    assign in_ready = !full;

    mia_front u_front (
        .item (in_data),
        .work (work)
    );

    mia_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !full),
        .push_data (work),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (empty)
    );

    mia_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== sv/mia_front.sv =====
// Front end: decodes one beat, works out simple results and prepares mul/div work.
`timescale 1ns / 1ps
module mia_front (
    input  mia_pkg::in_t   item,
    output mia_pkg::work_t work
);

    function automatic logic [63:0] mask_of(input logic [2:0] code);
        case (code)
            mia_pkg::WC_8:  mask_of = 64'h0000_0000_0000_00ff;
            mia_pkg::WC_16: mask_of = 64'h0000_0000_0000_ffff;
            mia_pkg::WC_32: mask_of = 64'h0000_0000_ffff_ffff;
            mia_pkg::WC_64: mask_of = 64'hffff_ffff_ffff_ffff;
            mia_pkg::WC_1:  mask_of = 64'h0000_0000_0000_0001;
            default:        mask_of = 64'h0;
        endcase
    endfunction

    function automatic logic [6:0] bits_of(input logic [2:0] code);
        case (code)
            mia_pkg::WC_8:  bits_of = 7'd8;
            mia_pkg::WC_16: bits_of = 7'd16;
            mia_pkg::WC_32: bits_of = 7'd32;
            mia_pkg::WC_64: bits_of = 7'd64;
            mia_pkg::WC_1:  bits_of = 7'd1;
            default:        bits_of = 7'd0;
        endcase
    endfunction

    logic [63:0] m, tm, a, b, sa, sb, ma, mb, bias_a, bias_b, sar_r;
    logic        na, nb, big_shift, bad_width;
    logic [5:0]  sh;

    always_comb begin
        m         = mask_of(item.width_code);
        tm        = mask_of(item.target_width_code);
        a         = item.left_operand & m;
        b         = item.right_operand & m;
        na        = |(a & (m ^ (m >> 1)));
        nb        = |(b & (m ^ (m >> 1)));
        sa        = na ? (a | ~m) : a;
        sb        = nb ? (b | ~m) : b;
        ma        = na ? (64'd0 - sa) : sa;
        mb        = nb ? (64'd0 - sb) : sb;
        bias_a    = sa ^ 64'h8000_0000_0000_0000;
        bias_b    = sb ^ 64'h8000_0000_0000_0000;
        big_shift = b >= {57'd0, bits_of(item.width_code)};
        sh        = b[5:0];
        sar_r     = ((a >> sh) | (na ? ~(m >> sh) : 64'd0)) & m;
        bad_width = (item.width_code > mia_pkg::WC_1)
                 || (item.width_code == mia_pkg::WC_1 && item.action != mia_pkg::ACT_CAST);

        work      = '0;
        work.cls  = mia_pkg::CLS_SIMPLE;
        work.mask = m;
        work.a    = a;
        work.b    = b;

        case (item.action)
            mia_pkg::ACT_UNARY: begin
                case (item.opcode)
                    mia_pkg::UN_NEG: work.res = (64'd0 - a) & m;
                    mia_pkg::UN_NOT: work.res = ~a & m;
                    default:         work.err = 1'b1;
                endcase
            end
            mia_pkg::ACT_BINARY: begin
                case (item.opcode)
                    mia_pkg::BIN_ADD: work.res = (a + b) & m;
                    mia_pkg::BIN_SUB: work.res = (a - b) & m;
                    mia_pkg::BIN_MUL: work.cls = mia_pkg::CLS_MUL;
                    mia_pkg::BIN_MODU: work.cls = mia_pkg::CLS_REM;
                    mia_pkg::BIN_DIVU: work.cls = mia_pkg::CLS_QUOT;
                    mia_pkg::BIN_MODS: begin
                        work.cls = mia_pkg::CLS_REM;
                        work.a   = ma;
                        work.b   = mb;
                        work.neg = na;
                    end
                    mia_pkg::BIN_DIVS: begin
                        work.cls = mia_pkg::CLS_QUOT;
                        work.a   = ma;
                        work.b   = mb;
                        work.neg = na ^ nb;
                    end
                    mia_pkg::BIN_SHR: work.res = big_shift ? 64'd0 : (a >> sh);
                    mia_pkg::BIN_SHL: work.res = big_shift ? 64'd0 : ((a << sh) & m);
                    mia_pkg::BIN_SAR: work.res = big_shift ? (na ? m : 64'd0) : sar_r;
                    mia_pkg::BIN_AND: work.res = a & b;
                    mia_pkg::BIN_OR:  work.res = a | b;
                    mia_pkg::BIN_XOR: work.res = a ^ b;
                    default:          work.err = 1'b1;
                endcase
                if ((item.opcode inside {[mia_pkg::BIN_MODU:mia_pkg::BIN_DIVS]}) && b == 64'd0)
                begin
                    work.err = 1'b1;
                end
            end
            mia_pkg::ACT_COMPARE: begin
                case (item.opcode)
                    mia_pkg::CMP_EQ:  work.res = {63'd0, a == b};
                    mia_pkg::CMP_NE:  work.res = {63'd0, a != b};
                    mia_pkg::CMP_GTU: work.res = {63'd0, a > b};
                    mia_pkg::CMP_GEU: work.res = {63'd0, a >= b};
                    mia_pkg::CMP_GTS: work.res = {63'd0, bias_a > bias_b};
                    mia_pkg::CMP_GES: work.res = {63'd0, bias_a >= bias_b};
                    mia_pkg::CMP_LTU: work.res = {63'd0, a < b};
                    mia_pkg::CMP_LEU: work.res = {63'd0, a <= b};
                    mia_pkg::CMP_LTS: work.res = {63'd0, bias_a < bias_b};
                    mia_pkg::CMP_LES: work.res = {63'd0, bias_a <= bias_b};
                    default:          work.err = 1'b1;
                endcase
            end
            default: begin
                if (item.target_width_code > mia_pkg::WC_1 || item.opcode > mia_pkg::CAST_SEXT)
                begin
                    work.err = 1'b1;
                end else begin
                    work.res = (a & tm)
                             | ((item.opcode == mia_pkg::CAST_SEXT && na) ? (tm & ~m) : 64'd0);
                end
            end
        endcase

        if (bad_width) begin
            work.err = 1'b1;
        end
        if (work.err) begin
            work.cls = mia_pkg::CLS_SIMPLE;
            work.res = 64'd0;
        end
    end

endmodule

// ===== sv/mia_fifo.sv =====
// Short queue between the decode front end and the execution back end.
`timescale 1ns / 1ps
`include "multiwidth_integer_alu_macros.svh"
module mia_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mia_pkg::work_t push_data,
    output logic           full,
    input  logic           pop,
    output mia_pkg::work_t pop_data,
    output logic           empty
);

    localparam int PTR_W = $clog2(mia_pkg::QUEUE_DEPTH);

    mia_pkg::work_t mem [mia_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full     = count_reg == (PTR_W + 1)'(mia_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `MIA_NEVER(a_count_bound, clk, rst_n, count_reg > (PTR_W + 1)'(mia_pkg::QUEUE_DEPTH), "queue overfilled")
    `MIA_ASSERT(a_push_only, clk, rst_n, push && !pop |=> count_reg == $past(count_reg) + 1'b1, "push lost")
    `MIA_ASSERT(a_pop_only, clk, rst_n, pop && !push |=> count_reg == $past(count_reg) - 1'b1, "pop lost")

endmodule

// ===== sv/mia_back.sv =====
// Back end: multiplier, bit-per-stage divider pipeline and output register.
`timescale 1ns / 1ps
module mia_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  mia_pkg::work_t q_data,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output mia_pkg::out_t  out_data
);

    localparam int N = mia_pkg::DIV_STAGES;

    typedef struct packed {
        logic [1:0]  cls;
        logic        err;
        logic        neg;
        logic [63:0] res;
        logic [63:0] mask;
        logic [63:0] d;
        logic [63:0] rem;
        logic [63:0] nq;
        logic [63:0] pp_ll;
        logic [31:0] pp_lh;
        logic [31:0] pp_hl;
    } st_t;

    function automatic st_t div_step(input st_t s);
        st_t         o;
        logic [64:0] rr;
        logic [65:0] diff;
        logic        ge;
        o     = s;
        rr    = {s.rem, s.nq[63]};
        diff  = {1'b0, rr} - {2'b00, s.d};
        ge    = !diff[65];
        o.nq  = {s.nq[62:0], ge};
        o.rem = ge ? diff[63:0] : rr[63:0];
        return o;
    endfunction

    logic        adv;
    logic        vld_reg [N+1];
    st_t         st_reg  [N+1];
    logic        out_valid_reg;
    mia_pkg::out_t out_data_reg, out_data_next;
    st_t         st_in, last;
    logic [63:0] prod, sel, fixed;

    assign adv       = !out_valid_reg || out_ready;
    assign q_pop     = adv && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        st_in       = '0;
        st_in.cls   = q_data.cls;
        st_in.err   = q_data.err;
        st_in.neg   = q_data.neg;
        st_in.res   = q_data.res;
        st_in.mask  = q_data.mask;
        st_in.d     = q_data.b;
        st_in.rem   = 64'd0;
        st_in.nq    = q_data.a;
        st_in.pp_ll = q_data.a[31:0] * q_data.b[31:0];
        st_in.pp_lh = 32'(q_data.a[31:0] * q_data.b[63:32]);
        st_in.pp_hl = 32'(q_data.a[63:32] * q_data.b[31:0]);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= !q_empty;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            st_reg[0] <= st_in;
        end
    end

    for (genvar i = 1; i <= N; i++) begin : g_stage
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[i] <= 1'b0;
            end else if (adv) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end

        always_ff @(posedge clk) begin
            if (adv) begin
                st_reg[i] <= div_step(st_reg[i-1]);
            end
        end
    end

    always_comb begin
        last  = st_reg[N];
        prod  = last.pp_ll + {last.pp_lh + last.pp_hl, 32'd0};
        sel   = (last.cls == mia_pkg::CLS_QUOT) ? last.nq : last.rem;
        fixed = last.neg ? (64'd0 - sel) : sel;
        out_data_next.error_flag = last.err;
        case (last.cls)
            mia_pkg::CLS_SIMPLE: out_data_next.result_value = last.res;
            mia_pkg::CLS_MUL:    out_data_next.result_value = prod & last.mask;
            default:             out_data_next.result_value = fixed & last.mask;
        endcase
        if (last.err) begin
            out_data_next.result_value = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= vld_reg[N];
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== tb/sv/mia_result_checker.sv =====
// Checker for the multi-width integer ALU: predicts each result and compares it.
`timescale 1ns / 1ps
module mia_result_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  mia_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  mia_pkg::out_t out_data,
    output int            fail_count,
    output int            pending_count,
    output int            seen_count
);
    import mia_pkg::*;

    out_t alu_expected_q[$];

    function automatic int bits_of(logic [2:0] code);
        case (code)
            WC_8:    return 8;
            WC_16:   return 16;
            WC_32:   return 32;
            WC_64:   return 64;
            WC_1:    return 1;
            default: return 0;
        endcase
    endfunction

    function automatic logic [63:0] mask_for(int n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic out_t compute_alu(in_t t);
        out_t r;
        int n;
        int tn;
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] tm;
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic signed [63:0] sar_v;
        logic na;
        logic [63:0] q;
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        r = '0;
        n = bits_of(t.width_code);
        if (n == 0 || (n == 1 && t.action != ACT_CAST)) begin
            r.error_flag = 1'b1;
            return r;
        end
        m = mask_for(n);
        a = t.left_operand & m;
        b = t.right_operand & m;
        na = a[n-1];
        sa = na ? (a | ~m) : a;
        sb = b[n-1] ? (b | ~m) : b;
        mag_a = na ? (64'd0 - sa) : sa;
        mag_b = sb[63] ? (64'd0 - sb) : sb;
        case (t.action)
            ACT_UNARY:
                if (t.opcode == UN_NEG) r.result_value = (-a) & m;
                else if (t.opcode == UN_NOT) r.result_value = ~a & m;
                else r.error_flag = 1'b1;
            ACT_BINARY:
                case (t.opcode)
                    BIN_ADD: r.result_value = (a + b) & m;
                    BIN_SUB: r.result_value = (a - b) & m;
                    BIN_MUL: r.result_value = (a * b) & m;
                    BIN_MODU, BIN_DIVU, BIN_MODS, BIN_DIVS:
                        if (b == 0) r.error_flag = 1'b1;
                        else if (t.opcode == BIN_MODU) r.result_value = a % b;
                        else if (t.opcode == BIN_DIVU) r.result_value = a / b;
                        else begin
                            if (t.opcode == BIN_MODS) begin
                                q = mag_a % mag_b;
                                r.result_value = (na ? -q : q) & m;
                            end else begin
                                q = mag_a / mag_b;
                                r.result_value = ((na != sb[63]) ? -q : q) & m;
                            end
                        end
                    BIN_SHR: r.result_value = (b >= n) ? '0 : (a >> b);
                    BIN_SHL: r.result_value = (b >= n) ? '0 : ((a << b) & m);
                    BIN_SAR:
                    begin
                        sar_v = sa >>> b;
                        r.result_value = (b >= n) ? (na ? m : '0) : (sar_v & m);
                    end
                    BIN_AND: r.result_value = a & b;
                    BIN_OR:  r.result_value = a | b;
                    BIN_XOR: r.result_value = a ^ b;
                    default: r.error_flag = 1'b1;
                endcase
            ACT_COMPARE:
                case (t.opcode)
                    CMP_EQ:  r.result_value = 64'(a == b);
                    CMP_NE:  r.result_value = 64'(a != b);
                    CMP_GTU: r.result_value = 64'(a > b);
                    CMP_GEU: r.result_value = 64'(a >= b);
                    CMP_GTS: r.result_value = 64'(sa > sb);
                    CMP_GES: r.result_value = 64'(sa >= sb);
                    CMP_LTU: r.result_value = 64'(a < b);
                    CMP_LEU: r.result_value = 64'(a <= b);
                    CMP_LTS: r.result_value = 64'(sa < sb);
                    CMP_LES: r.result_value = 64'(sa <= sb);
                    default: r.error_flag = 1'b1;
                endcase
            default: begin
                tn = bits_of(t.target_width_code);
                if (tn == 0 || t.opcode > CAST_SEXT) r.error_flag = 1'b1;
                else begin
                    tm = mask_for(tn);
                    r.result_value = a & tm;
                    if (t.opcode == CAST_SEXT && na) r.result_value |= tm & ~m;
                end
            end
        endcase
        if (r.error_flag) r.result_value = '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        fail_count++;
        $display("MISMATCH %s at %0t: got %h expected %h", what, $realtime, got, want);
    endtask

    initial begin
        fail_count = 0;
        seen_count = 0;
    end

    assign pending_count = alu_expected_q.size();

    always @(posedge clk) begin
        out_t want;
        if (rst_n) begin
            if (in_valid && in_ready) alu_expected_q.push_back(compute_alu(in_data));
            if (out_valid && out_ready) begin
                seen_count++;
                if (alu_expected_q.size() == 0) begin
                    report_mismatch("unexpected beat", out_data.result_value, '0);
                end else begin
                    want = alu_expected_q.pop_front();
                    if (out_data.result_value !== want.result_value)
                        report_mismatch("result_value", out_data.result_value,
                                        want.result_value);
                    if (out_data.error_flag !== want.error_flag)
                        report_mismatch("error_flag", out_data.error_flag,
                                        want.error_flag);
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb_multiwidth_integer_alu.sv =====
// Testbench top for the multi-width integer ALU: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_multiwidth_integer_alu;
    import mia_pkg::*;

    localparam int RANDOM_OPS = 1400;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    int fail_count;
    int pending_count;
    int seen_count;
    int cycle_count;
    int sent_count;
    bit stimulus_done;

    multiwidth_integer_alu DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    mia_result_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending_count(pending_count), .seen_count(seen_count)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("tb_multiwidth_integer_alu NOT OK");
            $finish;
        end
    end

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000 >> (8 * $urandom_range(0, 7));
            3: return 64'($urandom_range(0, 3));
            4: return {56'h0, 8'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_beat(in_t beat);
        int gap;
        gap = $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_op(logic [1:0] act, logic [3:0] op, logic [2:0] wc, logic [2:0] twc,
                           logic [63:0] a, logic [63:0] b);
        in_t beat;
        beat.action = act;
        beat.opcode = op;
        beat.width_code = wc;
        beat.target_width_code = twc;
        beat.left_operand = a;
        beat.right_operand = b;
        send_beat(beat);
    endtask

    initial begin
        int wait_n;
        out_ready = 1'b0;
        wait (rst_n);
        forever begin
            wait_n = stimulus_done ? 0 : $urandom_range(0, 14);
            if (wait_n > 0) begin
                out_ready <= 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin
        in_t beat;
        cycle_count = 0;
        sent_count = 0;
        stimulus_done = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_op(ACT_BINARY, BIN_DIVU, WC_32, WC_8, 64'd7, 64'd0);
        send_op(ACT_BINARY, BIN_MODS, WC_64, WC_8, 64'd7, 64'd0);
        send_op(ACT_BINARY, BIN_DIVS, WC_8, WC_8, 64'h80, 64'hFF);
        send_op(ACT_BINARY, BIN_MODS, WC_16, WC_8, 64'h8000, 64'hFFFF);
        send_op(ACT_BINARY, BIN_DIVS, WC_64, WC_8, 64'h8000_0000_0000_0000, '1);
        send_op(ACT_BINARY, BIN_DIVS, WC_32, WC_8, 64'hFFFF_FFF9, 64'd2);
        send_op(ACT_BINARY, BIN_MODS, WC_32, WC_8, 64'hFFFF_FFF9, 64'd2);
        send_op(ACT_BINARY, BIN_SAR, WC_8, WC_8, 64'h80, 64'd8);
        send_op(ACT_BINARY, BIN_SAR, WC_64, WC_8, '1, 64'd63);
        send_op(ACT_BINARY, BIN_SHL, WC_16, WC_8, 64'h1, 64'd16);
        send_op(ACT_BINARY, BIN_SHR, WC_64, WC_8, '1, '1);
        send_op(ACT_BINARY, BIN_MUL, WC_64, WC_8, '1, '1);
        send_op(ACT_BINARY, 4'd13, WC_8, WC_8, 64'd1, 64'd1);
        send_op(ACT_UNARY, UN_NEG, WC_8, WC_8, 64'h80, '0);
        send_op(ACT_UNARY, UN_NOT, WC_64, WC_8, '0, '0);
        send_op(ACT_UNARY, 4'd15, WC_8, WC_8, '1, '1);
        send_op(ACT_COMPARE, CMP_LTS, WC_8, WC_8, 64'h80, 64'h7F);
        send_op(ACT_COMPARE, CMP_GTU, WC_64, WC_8, '1, '0);
        send_op(ACT_COMPARE, 4'd10, WC_32, WC_8, '0, '0);
        send_op(ACT_CAST, CAST_SEXT, WC_1, WC_64, 64'h1, '0);
        send_op(ACT_CAST, CAST_SEXT, WC_8, WC_32, 64'hF0, '0);
        send_op(ACT_CAST, CAST_SEXT, WC_32, WC_8, 64'hFFFF_FF80, '0);
        send_op(ACT_CAST, 4'd4, WC_8, WC_16, '1, '0);
        send_op(ACT_CAST, 4'd1, WC_16, 3'd7, '1, '0);
        send_op(ACT_UNARY, UN_NEG, WC_1, WC_8, '1, '0);
        send_op(ACT_BINARY, BIN_ADD, 3'd7, WC_8, '1, '1);

        for (int i = 0; i < RANDOM_OPS; i++) begin
            beat.action = 2'($urandom);
            beat.opcode = ($urandom_range(0, 19) == 0) ? 4'($urandom) :
                          4'($urandom_range(0, 12));
            beat.width_code = ($urandom_range(0, 19) == 0) ? 3'($urandom) :
                              3'($urandom_range(0, 3));
            if (beat.action == ACT_CAST && $urandom_range(0, 3) == 0) beat.width_code = WC_1;
            beat.target_width_code = ($urandom_range(0, 19) == 0) ? 3'($urandom) :
                                     3'($urandom_range(0, 4));
            beat.left_operand = pick_operand();
            beat.right_operand = pick_operand();
            if (beat.opcode == BIN_SHL || beat.opcode == BIN_SAR || beat.opcode == BIN_SHR)
                if ($urandom_range(0, 1)) beat.right_operand = 64'($urandom_range(0, 70));
            send_beat(beat);
        end
        in_valid <= 1'b0;
        stimulus_done = 1;

        while (pending_count != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        $display("Sent %0d beats, checked %0d results across all actions, widths and casts.",
                 sent_count, seen_count);
        if (fail_count == 0)
            $display("tb_multiwidth_integer_alu OK");
        else
            $display("tb_multiwidth_integer_alu NOT OK");
        $finish;
    end
endmodule

// ===== multiwidth_integer_alu.f =====
+incdir+sv
sv/mia_pkg.sv
sv/mia_front.sv
sv/mia_fifo.sv
sv/mia_back.sv
sv/multiwidth_integer_alu.sv
tb/sv/mia_result_checker.sv
tb/sv/tb_multiwidth_integer_alu.sv
